// File: src/snp_pp_pkg.sv
// shared types, constants and helpers of the snp packet parser
package snp_pp_pkg;

  // payload fields are fixed at six bits (at most 60 data bytes)
  localparam int LEN_W = 6;
  localparam int PAYLOAD_DEPTH_DEF = 64;

  // header characters
  localparam logic [7:0] CH_S = 8'h73;
  localparam logic [7:0] CH_N = 8'h6e;
  localparam logic [7:0] CH_P = 8'h70;

  // running sum after a complete header
  localparam logic [15:0] SUM_INIT = 16'({8'h00, CH_S} + {8'h00, CH_N} + {8'h00, CH_P});

  // batch count field mask and single register length
  localparam logic [3:0] CNT_MASK = 4'hF;
  localparam logic [LEN_W-1:0] SINGLE_LEN = LEN_W'(4);

  // result status codes
  localparam logic ST_GOOD = 1'b0;
  localparam logic ST_BAD  = 1'b1;

  typedef enum logic [3:0] {
    PH_HUNT_S = 4'd0,
    PH_HUNT_N = 4'd1,
    PH_HUNT_P = 4'd2,
    PH_TYPE   = 4'd3,
    PH_ADDR   = 4'd4,
    PH_DATA   = 4'd5,
    PH_CK_HI  = 4'd6,
    PH_CK_LO  = 4'd7
  } phase_e;

  // one finished packet as seen by the back end
  typedef struct packed {
    logic             status;
    logic [7:0]       addr;
    logic [7:0]       ptype;
    logic [LEN_W-1:0] len;
  } desc_t;

  // front end to queue: payload write and descriptor push
  typedef struct packed {
    logic             we;
    logic [LEN_W-1:0] idx;
    logic [7:0]       data;
    logic             push;
    desc_t            desc;
  } fq_t;

  // queue to back end: oldest packet
  typedef struct packed {
    logic  valid;
    desc_t desc;
  } qb_t;

  // back end to queue: payload read and release
  typedef struct packed {
    logic             rd_en;
    logic [LEN_W-1:0] idx;
    logic             done;
  } bq_t;

  // one result item
  typedef struct packed {
    logic             status;
    logic [7:0]       addr;
    logic [7:0]       ptype;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] idx;
    logic [7:0]       data;
    logic             last;
  } res_t;

  // data length that a packet type byte announces
  function automatic logic [LEN_W-1:0] len_of_type(input logic [7:0] pt);
    logic [3:0] cnt;
    cnt = pt[5:2] & CNT_MASK;
    if (!pt[7]) begin
      return '0;
    end else if (pt[6]) begin
      return {cnt, 2'b00};
    end else begin
      return SINGLE_LEN;
    end
  endfunction

endpackage

// File: src/snp_pp_front.sv
// front end: header hunt, field capture, running sum and payload writes
module snp_pp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              acc_i,
  input  logic [7:0]        rx_byte_i,
  output snp_pp_pkg::fq_t   fq_o
);
  import snp_pp_pkg::*;

  phase_e           phase_q, phase_d;
  logic [7:0]       type_q, type_d;
  logic [7:0]       addr_q, addr_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] seen_q, seen_d;
  logic [15:0]      sum_q, sum_d;
  logic [7:0]       rxhi_q, rxhi_d;
  logic [15:0]      sum_add;
  logic [LEN_W-1:0] seen_inc;

  function automatic phase_e restart(input logic [7:0] b);
    return (b == CH_S) ? PH_HUNT_N : PH_HUNT_S;
  endfunction

  assign sum_add  = sum_q + {8'h00, rx_byte_i};
  assign seen_inc = seen_q + LEN_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT_S;
      type_q  <= '0;
      addr_q  <= '0;
      len_q   <= '0;
      seen_q  <= '0;
      sum_q   <= '0;
      rxhi_q  <= '0;
    end else begin
      phase_q <= phase_d;
      type_q  <= type_d;
      addr_q  <= addr_d;
      len_q   <= len_d;
      seen_q  <= seen_d;
      sum_q   <= sum_d;
      rxhi_q  <= rxhi_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    type_d  = type_q;
    addr_d  = addr_q;
    len_d   = len_q;
    seen_d  = seen_q;
    sum_d   = sum_q;
    rxhi_d  = rxhi_q;
    fq_o    = '0;
    if (acc_i) begin
      unique case (phase_q)
        PH_HUNT_N: begin
          phase_d = (rx_byte_i == CH_N) ? PH_HUNT_P : restart(rx_byte_i);
        end
        PH_HUNT_P: begin
          if (rx_byte_i == CH_P) begin
            phase_d = PH_TYPE;
            sum_d   = SUM_INIT;
          end else begin
            phase_d = restart(rx_byte_i);
          end
        end
        PH_TYPE: begin
          type_d  = rx_byte_i;
          len_d   = len_of_type(rx_byte_i);
          sum_d   = sum_add;
          phase_d = PH_ADDR;
        end
        PH_ADDR: begin
          addr_d  = rx_byte_i;
          sum_d   = sum_add;
          seen_d  = '0;
          phase_d = (len_q == '0) ? PH_CK_HI : PH_DATA;
        end
        PH_DATA: begin
          fq_o.we   = 1'b1;
          fq_o.idx  = seen_q;
          fq_o.data = rx_byte_i;
          sum_d     = sum_add;
          seen_d    = seen_inc;
          if (seen_inc >= len_q) begin
            phase_d = PH_CK_HI;
          end
        end
        PH_CK_HI: begin
          rxhi_d  = rx_byte_i;
          phase_d = PH_CK_LO;
        end
        PH_CK_LO: begin
          fq_o.push        = 1'b1;
          fq_o.desc.status = ({rxhi_q, rx_byte_i} != sum_q) ? ST_BAD : ST_GOOD;
          fq_o.desc.addr   = addr_q;
          fq_o.desc.ptype  = type_q;
          fq_o.desc.len    = len_q;
          phase_d          = PH_HUNT_S;
        end
        default: begin
          phase_d = restart(rx_byte_i);
        end
      endcase
    end
  end

endmodule

// File: src/snp_pp_queue.sv
// two-packet queue between front and back: descriptors and banked payload memory
module snp_pp_queue #(
  parameter int PAYLOAD_DEPTH = snp_pp_pkg::PAYLOAD_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  snp_pp_pkg::fq_t   fq_i,
  output logic              full_o,
  output snp_pp_pkg::qb_t   qb_o,
  input  snp_pp_pkg::bq_t   bq_i,
  output logic [7:0]        rd_data_o
);
  import snp_pp_pkg::*;

  localparam int AW = $clog2(PAYLOAD_DEPTH);
  localparam int MEM_DEPTH = 2 * (2 ** AW);

  logic [7:0] mem [MEM_DEPTH];
  desc_t      desc_q [2];
  logic [1:0] busy_q, busy_d;
  logic       wr_bank_q;
  logic       rd_bank_q;

  assign full_o = busy_q[wr_bank_q];

  always_comb begin
    busy_d = busy_q;
    if (fq_i.push) begin
      busy_d[wr_bank_q] = 1'b1;
    end
    if (bq_i.done) begin
      busy_d[rd_bank_q] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= '0;
      wr_bank_q <= 1'b0;
      rd_bank_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      if (fq_i.push) begin
        wr_bank_q <= ~wr_bank_q;
      end
      if (bq_i.done) begin
        rd_bank_q <= ~rd_bank_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fq_i.push) begin
      desc_q[wr_bank_q] <= fq_i.desc;
    end
  end

  // payload memory, one bank per queued packet
  always_ff @(posedge clk_i) begin
    if (fq_i.we) begin
      mem[{wr_bank_q, fq_i.idx[AW-1:0]}] <= fq_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bq_i.rd_en) begin
      rd_data_o <= mem[{rd_bank_q, bq_i.idx[AW-1:0]}];
    end
  end

  assign qb_o.valid = busy_q[rd_bank_q];
  assign qb_o.desc  = desc_q[rd_bank_q];

  a_wr_free_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fq_i.we || fq_i.push) |-> !busy_q[wr_bank_q])
    else $error("front writes into a bank still owned by the back end");

  a_done_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bq_i.done |-> busy_q[rd_bank_q])
    else $error("back end releases a bank it does not own");

endmodule

// File: src/snp_pp_back.sv
// back end: walks a queued packet and emits its results through a small output fifo
module snp_pp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  snp_pp_pkg::qb_t   qb_i,
  output snp_pp_pkg::bq_t   bq_o,
  input  logic [7:0]        rd_data_i,
  input  logic              pop_i,
  output logic              empty_o,
  output snp_pp_pkg::res_t  res_o
);
  import snp_pp_pkg::*;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW = $clog2(OQ_DEPTH);
  localparam int OQ_CW = OQ_AW + 1;

  logic [LEN_W-1:0] idx_q, idx_d;
  logic [LEN_W-1:0] n_res;
  logic [LEN_W-1:0] idx_inc;
  logic             use_mem;
  logic             last;
  logic             room;
  logic             issue;

  logic             s1_valid_q;
  logic             s1_mem_q;
  res_t             s1_res_q;
  res_t             push_res;

  res_t             oq_mem [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [OQ_CW-1:0] cnt_q, cnt_d;
  logic             do_pop;

  // a good packet with data gives one result per byte, anything else one result
  assign use_mem = (qb_i.desc.status == ST_GOOD) && (qb_i.desc.len != '0);
  assign n_res   = use_mem ? qb_i.desc.len : LEN_W'(1);
  assign idx_inc = idx_q + LEN_W'(1);
  assign last    = (idx_inc == n_res);

  // reserve a fifo slot for the read in flight
  assign room  = ({1'b0, cnt_q} + {{OQ_CW{1'b0}}, s1_valid_q}) < (OQ_CW + 1)'(OQ_DEPTH);
  assign issue = qb_i.valid && room;

  assign bq_o.rd_en = issue;
  assign bq_o.idx   = idx_q;
  assign bq_o.done  = issue && last;

  always_comb begin
    idx_d = idx_q;
    if (issue) begin
      idx_d = last ? '0 : idx_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      idx_q      <= idx_d;
      s1_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_mem_q        <= use_mem;
      s1_res_q.status <= qb_i.desc.status;
      s1_res_q.addr   <= qb_i.desc.addr;
      s1_res_q.ptype  <= qb_i.desc.ptype;
      s1_res_q.len    <= qb_i.desc.len;
      s1_res_q.idx    <= idx_q;
      s1_res_q.data   <= '0;
      s1_res_q.last   <= last;
    end
  end

  always_comb begin
    push_res      = s1_res_q;
    push_res.data = s1_mem_q ? rd_data_i : 8'h00;
  end

  // output fifo
  assign do_pop  = pop_i && (cnt_q != '0);
  assign empty_o = (cnt_q == '0);
  assign res_o   = oq_mem[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (s1_valid_q && !do_pop) begin
      cnt_d = cnt_q + OQ_CW'(1);
    end else if (!s1_valid_q && do_pop) begin
      cnt_d = cnt_q - OQ_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (s1_valid_q) begin
        wr_ptr_q <= wr_ptr_q + OQ_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + OQ_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      oq_mem[wr_ptr_q] <= push_res;
    end
  end

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= OQ_CW'(OQ_DEPTH))
    else $error("output fifo overflow");

  a_idx_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bq_o.done |=> (idx_q == '0))
    else $error("result index not restarted after a packet");

endmodule

// File: src/snp_packet_parser_core.sv
// top level of the snp packet parser: front end, packet queue and back end
// after the checksum low byte a result passes queue, back-end stage and output fifo
// a byte per cycle in; a result per cycle out while a packet drains and fifo has room
// input stalls (full high) only when both payload banks hold packets not yet fully read
// reset: asynchronous active low; hunting restarts, queue and output fifo empty
// payload memory needs no clearing: every entry used was written for the same packet
module snp_packet_parser_core #(
  parameter int PAYLOAD_DEPTH = snp_pp_pkg::PAYLOAD_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // byte input, queue style
  input  logic                         push,
  output logic                         full,
  input  logic [7:0]                   rx_byte_i,
  // result output, queue style
  output logic                         empty,
  input  logic                         pop,
  output logic                         status_o,
  output logic [7:0]                   reg_address_o,
  output logic [7:0]                   packet_type_o,
  output logic [snp_pp_pkg::LEN_W-1:0] payload_length_o,
  output logic [snp_pp_pkg::LEN_W-1:0] byte_index_o,
  output logic [7:0]                   payload_byte_o,
  output logic                         last_o
);
  import snp_pp_pkg::*;

  fq_t        fq;
  qb_t        qb;
  bq_t        bq;
  res_t       res;
  logic [7:0] rd_data;
  logic       acc;

  // a byte transfer happens whenever a byte is pushed and the front bank is free
  assign acc = push && !full;

  // front: hunt, classify and buffer
  snp_pp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .rx_byte_i (rx_byte_i),
    .fq_o      (fq)
  );

  // queue: two banks, so one packet can fill while the other drains
  snp_pp_queue #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fq_i      (fq),
    .full_o    (full),
    .qb_o      (qb),
    .bq_i      (bq),
    .rd_data_o (rd_data)
  );

  // back: one result per cycle into the output fifo while it has room
  snp_pp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .qb_i      (qb),
    .bq_o      (bq),
    .rd_data_i (rd_data),
    .pop_i     (pop),
    .empty_o   (empty),
    .res_o     (res)
  );

  assign status_o         = res.status;
  assign reg_address_o    = res.addr;
  assign packet_type_o    = res.ptype;
  assign payload_length_o = res.len;
  assign byte_index_o     = res.idx;
  assign payload_byte_o   = res.data;
  assign last_o           = res.last;

endmodule

// File: tb/snp_packet_parser_core_test.sv
// self-checking testbench of the snp packet parser core
module snp_packet_parser_core_test;
  import snp_pp_pkg::*;

  // run shape
  localparam int TOTAL_BYTES  = 260;  // bytes sent over the whole run, give or take a packet
  localparam int RX_HOLD      = 400;  // cycles the result side holds off under pressure
  localparam int IDLE_LIMIT   = 3000; // cycles without any transfer before giving up
  localparam int DRAIN_CYCLES = 8;    // cycles of quiet after the last owed result has arrived

  // ways a generated packet can be spoilt
  typedef enum int {
    FLAW_NONE,
    FLAW_CK_HI,
    FLAW_CK_LO,
    FLAW_SHORT
  } flaw_e;

  // one row of the directed stimulus, optionally with its result written out by hand
  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    res_t       want;
  } row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 push = 1'b0;
  logic                 full;
  logic [7:0]           rx_byte_i = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic                 status_o;
  logic [7:0]           reg_address_o;
  logic [7:0]           packet_type_o;
  logic [LEN_W-1:0]     payload_length_o;
  logic [LEN_W-1:0]     byte_index_o;
  logic [7:0]           payload_byte_o;
  logic                 last_o;

  snp_packet_parser_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .rx_byte_i        (rx_byte_i),
    .empty            (empty),
    .pop              (pop),
    .status_o         (status_o),
    .reg_address_o    (reg_address_o),
    .packet_type_o    (packet_type_o),
    .payload_length_o (payload_length_o),
    .byte_index_o     (byte_index_o),
    .payload_byte_o   (payload_byte_o),
    .last_o           (last_o)
  );

  // 8 unit period, high and low halves
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // parser state as the predictor sees it
  phase_e           hunt_ph = PH_HUNT_S;
  logic [7:0]       pkt_type = '0;
  logic [7:0]       pkt_addr = '0;
  logic [LEN_W-1:0] pkt_len = '0;
  logic [LEN_W-1:0] data_cnt = '0;
  logic [15:0]      run_sum = '0;
  logic [7:0]       ck_hi = '0;
  logic [7:0]       pkt_data [64];

  // results still owed by the block, oldest first
  res_t pending_res [$];

  // hand-written expectation for the byte about to be sent
  logic use_typed = 1'b0;
  res_t typed_res = '0;

  row_t dir_rows [$];

  // idling control of the two sides; the hold request passes from byte side to result side
  bit tx_calm = 1'b0;
  bit tx_rush = 1'b0;
  bit rx_calm = 1'b0;
  bit rx_hold_req = 1'b0;

  // tallies
  int errors = 0;
  int bytes_in = 0;
  int pkt_bytes = 0;
  int pkts_done = 0;
  int bad_pkts = 0;
  int results_seen = 0;
  int full_cycles = 0;
  int pauses = 0;
  int idle_run = 0;

  // a byte that breaks the header still counts if it is a fresh 's'
  function automatic phase_e rehunt(input logic [7:0] b);
    return (b == CH_S) ? PH_HUNT_N : PH_HUNT_S;
  endfunction

  // payload size announced by the type byte: flags in bits 7 and 6, count in 5:2
  function automatic logic [LEN_W-1:0] announced_len(input logic [7:0] t);
    if (!t[7]) begin
      return '0;
    end else if (t[6]) begin
      return {t[5:2], 2'b00};
    end else begin
      return SINGLE_LEN;
    end
  endfunction

  function automatic void owe_result(input logic st, input logic [LEN_W-1:0] idx,
                                     input logic [7:0] d, input logic lst);
    res_t r;
    r.status = st;
    r.addr   = pkt_addr;
    r.ptype  = pkt_type;
    r.len    = pkt_len;
    r.idx    = idx;
    r.data   = d;
    r.last   = lst;
    pending_res.push_back(r);
  endfunction

  // advance the predicted parser by one byte, queueing whatever results it owes
  function automatic void parse_byte(input logic [7:0] b);
    case (hunt_ph)
      PH_HUNT_N: begin
        hunt_ph = (b == CH_N) ? PH_HUNT_P : rehunt(b);
      end
      PH_HUNT_P: begin
        if (b == CH_P) begin
          hunt_ph = PH_TYPE;
          run_sum = SUM_INIT;
        end else begin
          hunt_ph = rehunt(b);
        end
      end
      PH_TYPE: begin
        pkt_type = b;
        pkt_len  = announced_len(b);
        run_sum  = run_sum + 16'(b);
        hunt_ph  = PH_ADDR;
      end
      PH_ADDR: begin
        pkt_addr = b;
        run_sum  = run_sum + 16'(b);
        data_cnt = '0;
        hunt_ph  = (pkt_len == 0) ? PH_CK_HI : PH_DATA;
      end
      PH_DATA: begin
        pkt_data[data_cnt] = b;
        run_sum  = run_sum + 16'(b);
        data_cnt = data_cnt + LEN_W'(1);
        if (data_cnt >= pkt_len) begin
          hunt_ph = PH_CK_HI;
        end
      end
      PH_CK_HI: begin
        ck_hi   = b;
        hunt_ph = PH_CK_LO;
      end
      PH_CK_LO: begin
        pkts_done++;
        if ({ck_hi, b} != run_sum) begin
          // mismatch: a single error result, no payload
          bad_pkts++;
          owe_result(ST_BAD, '0, 8'h00, 1'b1);
        end else if (pkt_len == 0) begin
          owe_result(ST_GOOD, '0, 8'h00, 1'b1);
        end else begin
          for (int i = 0; i < int'(pkt_len); i++) begin
            owe_result(ST_GOOD, LEN_W'(i), pkt_data[i], (i + 1 == int'(pkt_len)));
          end
        end
        hunt_ph = PH_HUNT_S;
      end
      default: begin
        hunt_ph = rehunt(b);
      end
    endcase
  endfunction

  // mostly back to back, sometimes short gaps, rarely a long one
  function automatic int idle_len(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  task automatic tab(input logic [7:0] b);
    dir_rows.push_back(row_t'{b, 1'b0, res_t'('0)});
  endtask

  task automatic tab_res(input logic [7:0] b, input res_t want);
    dir_rows.push_back(row_t'{b, 1'b1, want});
  endtask

  // offer one byte, hold it until the transfer, then maybe idle
  task automatic send_byte(input logic [7:0] b);
    int n0;
    int gap;
    push      <= 1'b1;
    rx_byte_i <= b;
    do begin
      @(posedge clk_i);
      if (full) full_cycles++;
    end while (full);
    // transfer took place at this edge
    n0 = pending_res.size();
    parse_byte(b);
    if (use_typed) begin
      // the hand-written row stands in for what the predictor queued
      while (pending_res.size() > n0) pending_res.delete(pending_res.size() - 1);
      pending_res.push_back(typed_res);
      use_typed = 1'b0;
    end
    bytes_in++;
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    gap = idle_len(tx_calm || tx_rush);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // header, type, address, n data bytes and checksum, spoilt as asked
  task automatic send_packet(input logic [7:0] t, input logic [7:0] a, input int n,
                             input flaw_e flaw);
    logic [15:0] ck;
    logic [7:0]  d;
    int          sent;
    ck = SUM_INIT + 16'(t) + 16'(a);
    send_byte(CH_S);
    send_byte(CH_N);
    send_byte(CH_P);
    send_byte(t);
    send_byte(a);
    sent = (flaw == FLAW_SHORT && n > 0) ? n - 1 : n;
    for (int k = 0; k < sent; k++) begin
      d  = 8'($urandom);
      ck = ck + 16'(d);
      send_byte(d);
    end
    if (flaw == FLAW_CK_HI) ck[15:8] = ck[15:8] ^ 8'($urandom_range(1, 255));
    if (flaw == FLAW_CK_LO) ck[7:0] = ck[7:0] ^ 8'($urandom_range(1, 255));
    send_byte(ck[15:8]);
    send_byte(ck[7:0]);
    pkt_bytes += 7 + sent;
  endtask

  // stop offering until every owed result has been taken
  task automatic drain_pause();
    push <= 1'b0;
    wait (pending_res.size() == 0);
    @(posedge clk_i);
    pauses++;
  endtask

  // result side: take transfers, compare with the oldest owed result, idle at random
  initial begin
    res_t want;
    int   rx_gap;
    rx_gap = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        results_seen++;
        if (pending_res.size() == 0) begin
          $error("unexpected result: addr 0x%0h index %0d", reg_address_o, byte_index_o);
          errors++;
        end else begin
          want = pending_res.pop_front();
          check_field("status", want.status, status_o);
          check_field("reg_address", want.addr, reg_address_o);
          check_field("packet_type", want.ptype, packet_type_o);
          check_field("payload_length", want.len, payload_length_o);
          check_field("byte_index", want.idx, byte_index_o);
          check_field("payload_byte", want.data, payload_byte_o);
          check_field("last", want.last, last_o);
        end
      end
      if (rx_hold_req) begin
        // long hold-off so that both payload banks fill and the input stalls
        rx_hold_req = 1'b0;
        pop <= 1'b0;
        repeat (RX_HOLD) @(posedge clk_i);
      end else if (rx_gap > 0) begin
        pop <= 1'b0;
        rx_gap--;
      end else begin
        pop <= 1'b1;
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        rx_gap = idle_len(rx_calm);
      end
    end
  end

  // watchdog: any stretch without a transfer on either side that runs too long
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      idle_run = 0;
    end else begin
      idle_run++;
      if (idle_run >= IDLE_LIMIT) begin
        $error("no transfer for %0d cycles, %0d results still owed", idle_run,
               pending_res.size());
        $display("snp_packet_parser_core test failed");
        $finish;
      end
    end
  end

  // byte side: directed table, then random packets with noise and pressure phases
  initial begin
    logic [7:0] t;
    logic [3:0] cnt;
    int         c;
    int         f;
    int         n;
    flaw_e      flaw;
    bit         squeezed;

    squeezed = 1'b0;

    // header broken by a second 's' that restarts it, flag bit 6 set but bit 7 clear, so no data
    tab(CH_S); tab(CH_S); tab(CH_N); tab(CH_P); tab(8'h7F); tab(8'hFF); tab(8'h02);
    tab_res(8'hCF, res_t'{ST_GOOD, 8'hFF, 8'h7F, 6'd0, 6'd0, 8'h00, 1'b1});
    // batch with a zero count and a wrong checksum: one error result
    tab(CH_S); tab(CH_N); tab(CH_P); tab(8'hC0); tab(8'h00); tab(8'h01);
    tab_res(8'hFF, res_t'{ST_BAD, 8'h00, 8'hC0, 6'd0, 6'd0, 8'h00, 1'b1});
    // single register with extreme data values
    tab(CH_S); tab(CH_N); tab(CH_P); tab(8'h80); tab(8'h5A);
    tab(8'h00); tab(8'hFF); tab(8'hAA); tab(8'h55); tab(8'h04); tab(8'h29);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      use_typed = dir_rows[i].typed;
      typed_res = dir_rows[i].want;
      send_byte(dir_rows[i].b);
    end
    drain_pause();

    // largest payload first, then the random mix
    send_packet(8'hFC, 8'($urandom), 60, FLAW_NONE);
    while (bytes_in < TOTAL_BYTES) begin
      if (!squeezed && bytes_in >= TOTAL_BYTES / 2) begin
        // receiver holds off while packets keep coming back to back
        squeezed    = 1'b1;
        rx_hold_req = 1'b1;
        tx_rush     = 1'b1;
        repeat (4) send_packet(8'hD0, 8'($urandom), 16, FLAW_NONE);
        tx_rush = 1'b0;
      end
      if ($urandom_range(0, 99) < 8) begin
        // noise and stray header fragments between packets
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 3))
            0: send_byte(CH_S);
            1: send_byte(CH_N);
            2: send_byte(CH_P);
            default: send_byte(8'($urandom));
          endcase
        end
      end
      c = $urandom_range(0, 99);
      if (c < 12) begin
        t = {1'b0, 7'($urandom)};
        n = 0;
      end else if (c < 18) begin
        t = {2'b11, 4'd0, 2'($urandom)};
        n = 0;
      end else if (c < 38) begin
        t = {2'b10, 6'($urandom)};
        n = 4;
      end else begin
        cnt = (c < 96) ? 4'($urandom_range(1, 4)) : 4'($urandom_range(5, 15));
        t   = {2'b11, cnt, 2'($urandom)};
        n   = 4 * int'(cnt);
      end
      f = $urandom_range(0, 99);
      if (f < 82) flaw = FLAW_NONE;
      else if (f < 89) flaw = FLAW_CK_HI;
      else if (f < 96) flaw = FLAW_CK_LO;
      else flaw = (n > 0) ? FLAW_SHORT : FLAW_CK_LO;
      send_packet(t, 8'($urandom), n, flaw);
      if ($urandom_range(0, 99) < 5) drain_pause();
    end

    // wind down: everything owed must arrive, and nothing more
    push <= 1'b0;
    wait (pending_res.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d bytes sent (%0d in packets), %0d packets closed, %0d with bad checksum",
             bytes_in, pkt_bytes, pkts_done, bad_pkts);
    $display("%0d results checked, input stalled %0d cycles, %0d drain pauses",
             results_seen, full_cycles, pauses);
    if (errors == 0) begin
      $display("snp_packet_parser_core test passed");
    end else begin
      $display("snp_packet_parser_core test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/snp_pp_pkg.sv
src/snp_pp_front.sv
src/snp_pp_queue.sv
src/snp_pp_back.sv
src/snp_packet_parser_core.sv
tb/snp_packet_parser_core_test.sv
